>>> hdl/sbsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted score table search package
// Payload types and codes shared by the score table search block.
// ----------------------------------------------------------------------------
package sbsr_pkg;

   localparam int SCORE_W = 10;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 9;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [INDEX_W-1:0] entry_index;
      logic [SCORE_W-1:0] entry_score;
      logic [SCORE_W-1:0] target_score;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] first_match_res;
      logic [COUNT_W-1:0] match_count;
   } rsp_type;

endpackage

>>> hdl/sbsr_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Score table memory
// Single write port and one registered read port over the score entries.
// ----------------------------------------------------------------------------
module sbsr_table #(
   parameter int TABLE_DEPTH = 256,
   parameter int ADDR_W      = 8
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [sbsr_pkg::SCORE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [sbsr_pkg::SCORE_W-1:0] rd_data
);

   logic [sbsr_pkg::SCORE_W-1:0] mem_ff [TABLE_DEPTH];
   logic [sbsr_pkg::SCORE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/sorted_table_binary_search_range.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted score table binary search with equal range
// Stores sorted scores and answers queries with the first index and length
// of the run of entries equal to the target score.
// ----------------------------------------------------------------------------
//  Channel | Direction | Beat contents
//  req     | in        | load of one entry or a search query (req_type)
//  rsp     | out       | found, first match index, match count (rsp_type)
//  csr     | in        | entries_in_use, 9 bits
//
// A query issues each binary-search probe and each step of the walk over
// equal neighbors as a read in ST_PROBE, ST_LEFT or ST_RIGHT and compares
// the data in the matching check state, then loads the result in ST_FINISH;
// all reads go through the single registered read port of the table.
// Reset clears the sequencer, the result valid flag and entries_in_use.
// A load is taken while a result waits; a query waits for the result slot.
module sorted_table_binary_search_range #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  sbsr_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output sbsr_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sbsr_pkg::COUNT_W-1:0]       csr_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_PROBE_CHK,
      ST_LEFT,
      ST_LEFT_CHK,
      ST_RIGHT,
      ST_RIGHT_CHK,
      ST_FINISH
   } state_type;

   state_type                      state_ff;
   logic [sbsr_pkg::COUNT_W-1:0]   entries_ff;
   logic [CW-1:0]                  n_ff;
   logic [CW-1:0]                  lo_ff;
   logic [CW-1:0]                  hi_ff;
   logic [AW-1:0]                  mid_ff;
   logic [AW-1:0]                  start_ff;
   logic [AW-1:0]                  end_ff;
   logic                           hit_ff;
   logic [sbsr_pkg::SCORE_W-1:0]   target_ff;
   logic                           rsp_valid_ff;
   sbsr_pkg::rsp_type              rsp_data_ff;

   logic [CW:0]                    mid_sum;
   logic [AW-1:0]                  mid_in;
   logic [CW-1:0]                  end_next;
   logic [CW-1:0]                  count_in;
   logic [CW-1:0]                  n_in;
   logic                           req_beat;
   logic                           load_en;
   logic                           rd_en;
   logic [AW-1:0]                  rd_addr;
   logic [sbsr_pkg::SCORE_W-1:0]   rd_data;
   logic                           rd_eq;
   logic                           rd_lt;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_beat  = req_valid && req_ready;
   assign load_en   = req_beat && (req_data.operation == sbsr_pkg::OP_LOAD)
                      && (32'(req_data.entry_index) < TABLE_DEPTH);

   assign mid_sum  = (CW+1)'(lo_ff) + (CW+1)'(hi_ff) - (CW+1)'(1);
   assign mid_in   = AW'(mid_sum >> 1);
   assign end_next = CW'(end_ff) + CW'(1);
   assign count_in = CW'(end_ff) - CW'(start_ff) + CW'(1);
   assign n_in     = (32'(entries_ff) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entries_ff);
   assign rd_eq    = (rd_data == target_ff);
   assign rd_lt    = (rd_data < target_ff);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      case (state_ff)
         ST_PROBE: begin
            rd_en   = (lo_ff < hi_ff);
            rd_addr = mid_in;
         end
         ST_LEFT: begin
            rd_en   = (start_ff != '0);
            rd_addr = start_ff - AW'(1);
         end
         ST_RIGHT: begin
            rd_en   = (end_next < n_ff);
            rd_addr = AW'(end_next);
         end
         default: begin
            rd_en   = 1'b0;
            rd_addr = '0;
         end
      endcase
   end

   sbsr_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (AW'(req_data.entry_index)),
      .wr_data (req_data.entry_score),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            entries_ff <= csr_data;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_beat && (req_data.operation == sbsr_pkg::OP_QUERY)) begin
                  target_ff <= req_data.target_score;
                  n_ff      <= n_in;
                  lo_ff     <= '0;
                  hi_ff     <= n_in;
                  hit_ff    <= 1'b0;
                  state_ff  <= ST_PROBE;
               end
            end
            ST_PROBE: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_in;
                  state_ff <= ST_PROBE_CHK;
               end else begin
                  hit_ff   <= 1'b0;
                  state_ff <= ST_FINISH;
               end
            end
            ST_PROBE_CHK: begin
               if (rd_eq) begin
                  hit_ff   <= 1'b1;
                  start_ff <= mid_ff;
                  end_ff   <= mid_ff;
                  state_ff <= ST_LEFT;
               end else if (rd_lt) begin
                  lo_ff    <= CW'(mid_ff) + CW'(1);
                  state_ff <= ST_PROBE;
               end else begin
                  hi_ff    <= CW'(mid_ff);
                  state_ff <= ST_PROBE;
               end
            end
            ST_LEFT: begin
               state_ff <= (start_ff != '0) ? ST_LEFT_CHK : ST_RIGHT;
            end
            ST_LEFT_CHK: begin
               if (rd_eq) begin
                  start_ff <= start_ff - AW'(1);
                  state_ff <= ST_LEFT;
               end else begin
                  state_ff <= ST_RIGHT;
               end
            end
            ST_RIGHT: begin
               state_ff <= (end_next < n_ff) ? ST_RIGHT_CHK : ST_FINISH;
            end
            ST_RIGHT_CHK: begin
               if (rd_eq) begin
                  end_ff   <= AW'(end_next);
                  state_ff <= ST_RIGHT;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.found <= hit_ff;
                  rsp_data_ff.first_match_res <= hit_ff ?
                     sbsr_pkg::INDEX_W'(start_ff) : '0;
                  rsp_data_ff.match_count <= hit_ff ?
                     sbsr_pkg::COUNT_W'(count_in) : '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> tb/sorted_table_binary_search_range_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted score table search testbench
// Loads sorted score tables of varied sizes, sets the number of entries in
// use and issues searches while both channels stall at random. Every search
// answer is checked field by field against an in-bench search of the table.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_range_tb;

   localparam int TABLE_DEPTH   = 256;
   localparam int SCORE_MAX     = (1 << sbsr_pkg::SCORE_W) - 1;
   localparam int ITEM_GOAL     = 720;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 5000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   sbsr_pkg::req_type            req_data = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   sbsr_pkg::rsp_type            rsp_data;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [sbsr_pkg::COUNT_W-1:0] csr_data = '0;

   sbsr_pkg::req_type            pending_ops[$];
   sbsr_pkg::rsp_type            search_answers[$];
   logic [sbsr_pkg::SCORE_W-1:0] score_mem [TABLE_DEPTH];
   logic [sbsr_pkg::COUNT_W-1:0] used_cnt;
   logic [sbsr_pkg::SCORE_W-1:0] planned [TABLE_DEPTH];
   bit                           loaded [TABLE_DEPTH];
   int                           beats_taken = 0;
   int                           mismatches = 0;
   int                           stall_cycles = 0;
   int                           issued = 0;

   sorted_table_binary_search_range #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int send_idle_pct();
      if (beats_taken < 240) return 38;
      if (beats_taken < 480) return 73;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (beats_taken < 240) return 73;
      if (beats_taken < 480) return 38;
      return 0;
   endfunction

   function automatic sbsr_pkg::rsp_type search_range(
      input logic [sbsr_pkg::SCORE_W-1:0] target);
      int unsigned       n, lo, hi, mid, first, last;
      bit                hit;
      sbsr_pkg::rsp_type answer;
      n = (used_cnt > TABLE_DEPTH) ? TABLE_DEPTH : used_cnt;
      lo = 0;
      hi = n;
      mid = 0;
      hit = 1'b0;
      while (lo < hi && !hit) begin
         mid = (lo + hi - 1) / 2;
         if (score_mem[mid] == target)
            hit = 1'b1;
         else if (score_mem[mid] < target)
            lo = mid + 1;
         else
            hi = mid;
      end
      answer = '0;
      if (hit) begin
         first = mid;
         last = mid;
         while (first > 0 && score_mem[first-1] == target)
            first--;
         while (last + 1 < n && score_mem[last+1] == target)
            last++;
         answer.found = 1'b1;
         answer.first_match_res = sbsr_pkg::INDEX_W'(first);
         answer.match_count = sbsr_pkg::COUNT_W'(last - first + 1);
      end
      return answer;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
            req_valid <= 1'b1;
            req_data <= pending_ops.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
      end
   end

   always @(posedge clock) begin
      sbsr_pkg::rsp_type want;
      if (reset) begin
         used_cnt = '0;
      end else begin
         if (csr_valid && csr_ready)
            used_cnt = csr_data;
         if (req_valid && req_ready) begin
            beats_taken <= beats_taken + 1;
            if (req_data.operation == sbsr_pkg::OP_LOAD)
               score_mem[req_data.entry_index] = req_data.entry_score;
            else
               search_answers.push_back(search_range(req_data.target_score));
         end
         if (rsp_valid && rsp_ready) begin
            if (search_answers.size() == 0) begin
               $error("unexpected result beat: found %0d, first %0d, count %0d",
                      rsp_data.found, rsp_data.first_match_res, rsp_data.match_count);
               mismatches++;
            end else begin
               want = search_answers.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_data.found);
                  mismatches++;
               end
               if (rsp_data.first_match_res !== want.first_match_res) begin
                  $error("first_match_res: expected %0d, actual %0d",
                         want.first_match_res, rsp_data.first_match_res);
                  mismatches++;
               end
               if (rsp_data.match_count !== want.match_count) begin
                  $error("match_count: expected %0d, actual %0d",
                         want.match_count, rsp_data.match_count);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
                   || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_load(input int idx, input int score);
      sbsr_pkg::req_type beat;
      beat.operation = sbsr_pkg::OP_LOAD;
      beat.entry_index = sbsr_pkg::INDEX_W'(idx);
      beat.entry_score = sbsr_pkg::SCORE_W'(score);
      beat.target_score = sbsr_pkg::SCORE_W'($urandom);
      pending_ops.push_back(beat);
      planned[idx] = sbsr_pkg::SCORE_W'(score);
      loaded[idx] = 1'b1;
      issued++;
   endtask

   task automatic push_query(input int target);
      sbsr_pkg::req_type beat;
      beat.operation = sbsr_pkg::OP_QUERY;
      beat.entry_index = sbsr_pkg::INDEX_W'($urandom);
      beat.entry_score = sbsr_pkg::SCORE_W'($urandom);
      beat.target_score = sbsr_pkg::SCORE_W'(target);
      pending_ops.push_back(beat);
      issued++;
   endtask

   task automatic settle();
      do
         @(posedge clock);
      while (beats_taken < issued || search_answers.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entries_in_use(input int value);
      settle();
      csr_valid <= 1'b1;
      csr_data <= sbsr_pkg::COUNT_W'(value);
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic int loaded_prefix();
      int n;
      n = 0;
      while (n < TABLE_DEPTH && loaded[n])
         n++;
      return n;
   endfunction

   function automatic int pick_target(input int n);
      int roll;
      roll = $urandom_range(0, 99);
      if (n > 0 && roll < 65)
         return planned[$urandom_range(0, n - 1)];
      if (n > 0 && roll < 80)
         return (planned[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : SCORE_MAX))
                & SCORE_MAX;
      return $urandom_range(0, SCORE_MAX);
   endfunction

   task automatic fill_sorted(input int count, input int dup_pct);
      int score;
      score = $urandom_range(0, 40);
      for (int i = 0; i < count; i++) begin
         if (i > 0 && $urandom_range(0, 99) >= dup_pct)
            score += $urandom_range(1, 12);
         if (score > SCORE_MAX)
            score = SCORE_MAX;
         push_load(i, score);
      end
   endtask

   initial begin : stimulus
      int phase_no;
      int count;
      int setting;
      int in_use;
      int prefix;
      phase_no = 0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         loaded[i] = 1'b0;
      wait (!reset);
      @(posedge clock);

      // Searches of an empty table, then a small table with equal runs.
      write_entries_in_use(0);
      push_query(0);
      push_query(SCORE_MAX);
      push_load(TABLE_DEPTH - 1, SCORE_MAX);
      push_load(0, 0);
      push_load(1, 0);
      push_load(2, 5);
      push_load(3, 5);
      push_load(4, 5);
      push_load(5, 700);
      push_load(6, 1000);
      push_load(7, SCORE_MAX);
      write_entries_in_use(8);
      push_query(0);
      push_query(5);
      push_query(700);
      push_query(1000);
      push_query(SCORE_MAX);
      push_query(3);
      push_query(1001);
      // An out-of-order entry makes the probes take another path.
      push_load(3, 900);
      push_query(5);
      write_entries_in_use(1);
      push_query(0);

      while (issued < ITEM_GOAL) begin
         if (phase_no == 4) begin
            fill_sorted(TABLE_DEPTH, 100);
            setting = (1 << sbsr_pkg::COUNT_W) - 1;
         end else begin
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 128)
                                                : $urandom_range(1, 24);
            fill_sorted(count, $urandom_range(20, 60));
            prefix = loaded_prefix();
            if ($urandom_range(0, 99) < 80)
               setting = count;
            else if (prefix == TABLE_DEPTH)
               setting = $urandom_range(0, (1 << sbsr_pkg::COUNT_W) - 1);
            else
               setting = $urandom_range(0, prefix);
         end
         write_entries_in_use(setting);
         in_use = (setting > TABLE_DEPTH) ? TABLE_DEPTH : setting;
         repeat ($urandom_range(6, 24)) begin
            if ($urandom_range(0, 99) < 12)
               push_load($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, SCORE_MAX));
            else
               push_query(pick_target(in_use));
         end
         phase_no++;
      end

      settle();
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> sorted_table_binary_search_range.f
hdl/sbsr_pkg.sv
hdl/sbsr_table.sv
hdl/sorted_table_binary_search_range.sv
tb/sorted_table_binary_search_range_tb.sv
